// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
package ffa_pkg;

    localparam int MaxSegments = 32;
    localparam int AddrBits    = 16;
    localparam int SizeBits    = AddrBits + 1;
    localparam int CntBits     = $clog2(MaxSegments + 1);
    localparam int IdxBits     = $clog2(MaxSegments);

    typedef logic [AddrBits-1:0] t_addr;
    typedef logic [SizeBits-1:0] t_size;
    typedef logic [CntBits-1:0]  t_cnt;

    // One segment of the table.
    typedef struct packed {
        t_addr start;
        t_size size;
        logic  free;
    } t_seg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Per-cycle command from the sequencer to every cell.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INIT,
        CMD_SPLIT,
        CMD_MARK_USED,
        CMD_FREE_MERGE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_cnt    idx;
        t_size   req;
        logic    merge_next;
        logic    merge_prev;
    } t_cell_cmd;

endpackage

// ===== rtl/first_fit_allocator_top.sv =====
// Top level of the first-fit segment allocator: sequencer plus a row of cells.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------
//  request   | i_req_valid/o_req_ready | i_req_type, i_req_size, i_free_offset
//  result    | o_rsp_valid/i_rsp_ready | o_status, o_granted_offset
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_data (pool size)
//
// A request scans the table entries in order until it finds a hit or runs past the
// last entry; a zero-size allocate skips the scan and goes straight to the result.
// Table updates (split, merge) happen in the same cycle across all cells.
// A config write resets the table to one free segment; reset gives a 65536 pool.
// Result stalls hold the block; no new word is taken until the result leaves.
module first_fit_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic        i_req_type,
    input  logic [16:0] i_req_size,
    input  logic [15:0] i_free_offset,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);
    import ffa_pkg::*;

    t_seg      w_seg [MaxSegments];
    t_cell_cmd w_cmd;
    t_size     w_pool;
    t_cnt      w_scan_idx;
    t_seg      w_scan_seg;
    t_seg      w_scan_next;
    t_seg      w_scan_prev;
    logic [IdxBits-1:0] w_sel;

    // Scan pointer views of the row.
    assign w_sel = w_scan_idx[IdxBits-1:0];
    always_comb begin
        w_scan_seg  = w_seg[w_sel];
        w_scan_next = (w_sel == IdxBits'(MaxSegments-1)) ? '0 : w_seg[w_sel + IdxBits'(1)];
        w_scan_prev = (w_sel == '0) ? '0 : w_seg[w_sel - IdxBits'(1)];
    end

    ffa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_req_valid, .o_req_ready, .i_req_type, .i_req_size,
        .i_free_offset, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_pool(w_pool), .i_scan_seg(w_scan_seg), .i_scan_next(w_scan_next),
        .i_scan_prev(w_scan_prev), .o_scan_idx(w_scan_idx), .o_cmd(w_cmd),
        .o_rsp_valid, .i_rsp_ready, .o_status, .o_granted_offset
    );

    // Row of cells, each wired to its neighbors.
    for (genvar g = 0; g < MaxSegments; g++) begin : g_cell
        t_seg w_prev, w_next, w_next2;
        assign w_prev  = (g > 0) ? w_seg[(g > 0) ? g-1 : 0] : '0;
        assign w_next  = (g < MaxSegments-1) ? w_seg[(g < MaxSegments-1) ? g+1 : g] : '0;
        assign w_next2 = (g < MaxSegments-2) ? w_seg[(g < MaxSegments-2) ? g+2 : g] : '0;
        ffa_cell u_cell (
            .i_clk, .i_rst_n,
            .i_pos(t_cnt'(g)),
            .i_pool(w_pool),
            .i_cmd(w_cmd),
            .i_prev(w_prev),
            .i_next(w_next),
            .i_next2(w_next2),
            .o_seg(w_seg[g])
        );
    end
endmodule

// ===== rtl/ffa_cell.sv =====
// One segment slot of the table; updates itself from its neighbors' contents.
module ffa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffa_pkg::t_cnt     i_pos,
    input  ffa_pkg::t_size    i_pool,
    input  ffa_pkg::t_cell_cmd i_cmd,
    input  ffa_pkg::t_seg     i_prev,
    input  ffa_pkg::t_seg     i_next,
    input  ffa_pkg::t_seg     i_next2,
    output ffa_pkg::t_seg     o_seg
);
    import ffa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;

    // Next contents given this cell's place relative to the target index.
    always_comb begin
        n_seg = r_seg;
        case (i_cmd.op)
            CMD_INIT: begin
                n_seg = '0;
                if (i_pos == '0) begin
                    n_seg.size = i_pool;
                    n_seg.free = 1'b1;
                end
            end
            CMD_SPLIT: begin
                if (i_pos == i_cmd.idx) begin
                    n_seg.size = i_cmd.req;
                    n_seg.free = 1'b0;
                end else if (i_pos == i_cmd.idx + t_cnt'(1)) begin
                    n_seg.start = i_prev.start + i_cmd.req[AddrBits-1:0];
                    n_seg.size  = i_prev.size - i_cmd.req;
                    n_seg.free  = 1'b1;
                end else if (i_pos > i_cmd.idx) begin
                    n_seg = i_prev;
                end
            end
            CMD_MARK_USED: begin
                if (i_pos == i_cmd.idx) n_seg.free = 1'b0;
            end
            CMD_FREE_MERGE: begin
                // Removing k entries after the merge: k = merge_next + merge_prev.
                if (i_cmd.merge_prev) begin
                    if (i_pos + t_cnt'(1) == i_cmd.idx) begin
                        n_seg.size = r_seg.size + i_next.size
                                   + (i_cmd.merge_next ? i_next2.size : '0);
                    end else if (i_pos >= i_cmd.idx) begin
                        n_seg = i_cmd.merge_next ? i_next2 : i_next;
                    end
                end else if (i_cmd.merge_next) begin
                    if (i_pos == i_cmd.idx) begin
                        n_seg.size = r_seg.size + i_next.size;
                        n_seg.free = 1'b1;
                    end else if (i_pos > i_cmd.idx) begin
                        n_seg = i_next;
                    end
                end else if (i_pos == i_cmd.idx) begin
                    n_seg.free = 1'b1;
                end
            end
            default: n_seg = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= (i_pos == '0)
                   ? t_seg'{start: '0, size: t_size'(1 << AddrBits), free: 1'b1}
                   : t_seg'('0);
        end else begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;
endmodule

// ===== rtl/ffa_ctrl.sv =====
// Request sequencer: scans the cell row one entry per cycle and issues updates.
module ffa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic               i_req_type,
    input  ffa_pkg::t_size     i_req_size,
    input  ffa_pkg::t_addr     i_free_offset,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  ffa_pkg::t_size     i_cfg_data,
    output ffa_pkg::t_size     o_pool,
    input  ffa_pkg::t_seg      i_scan_seg,
    input  ffa_pkg::t_seg      i_scan_next,
    input  ffa_pkg::t_seg      i_scan_prev,
    output ffa_pkg::t_cnt      o_scan_idx,
    output ffa_pkg::t_cell_cmd o_cmd,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [1:0]         o_status,
    output ffa_pkg::t_addr     o_granted_offset
);
    import ffa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state  r_state;
    t_cnt    r_count;
    t_cnt    r_idx;
    logic    r_type;
    t_size   r_req;
    t_addr   r_off;
    t_size   r_pool;
    t_status r_status;
    t_addr   r_granted;
    t_cell_cmd r_cmd;

    logic    w_cfg_take;
    t_size   w_pool_clip;
    logic    w_alloc_hit;
    logic    w_free_hit;

    assign o_req_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_cfg_take  = i_cfg_valid && o_cfg_ready;
    assign o_pool      = r_pool;
    assign o_scan_idx  = r_idx;
    assign o_cmd       = r_cmd;
    assign o_rsp_valid = (r_state == S_RESP);
    assign o_status    = r_status;
    assign o_granted_offset = r_granted;

    // Clamp the written pool size into range.
    always_comb begin
        w_pool_clip = i_cfg_data;
        if (i_cfg_data == '0) w_pool_clip = t_size'(1);
        if (i_cfg_data > t_size'(1 << AddrBits)) w_pool_clip = t_size'(1 << AddrBits);
    end

    assign w_alloc_hit = i_scan_seg.free && (i_scan_seg.size >= r_req);
    assign w_free_hit  = !i_scan_seg.free && (i_scan_seg.start == r_off);

    // Sequencer and registered result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= t_cnt'(1);
            r_idx   <= '0;
            r_pool  <= t_size'(1 << AddrBits);
            r_cmd   <= '{op: CMD_HOLD, default: '0};
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_take) begin
                        r_pool   <= w_pool_clip;
                        r_count  <= t_cnt'(1);
                        r_cmd.op <= CMD_INIT;
                    end else begin
                        r_cmd.op <= CMD_HOLD;
                        if (i_req_valid) begin
                            r_type <= i_req_type;
                            r_req  <= i_req_size;
                            r_off  <= i_free_offset;
                            r_idx  <= '0;
                            if (!i_req_type && i_req_size == '0) begin
                                r_status  <= ST_BAD;
                                r_granted <= '0;
                                r_state   <= S_RESP;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx >= r_count) begin
                        r_cmd.op  <= CMD_HOLD;
                        r_granted <= '0;
                        r_status  <= r_type ? ST_BAD : ST_NOFIT;
                        r_state   <= S_RESP;
                    end else if (!r_type && w_alloc_hit) begin
                        r_state <= S_RESP;
                        if (i_scan_seg.size == r_req) begin
                            r_status  <= ST_OK;
                            r_granted <= i_scan_seg.start;
                            r_cmd.op  <= CMD_MARK_USED;
                            r_cmd.idx <= r_idx;
                        end else if (r_count >= t_cnt'(MaxSegments)) begin
                            r_cmd.op  <= CMD_HOLD;
                            r_granted <= '0;
                            r_status  <= ST_FULL;
                        end else begin
                            r_status  <= ST_OK;
                            r_granted <= i_scan_seg.start;
                            r_cmd.op  <= CMD_SPLIT;
                            r_cmd.idx <= r_idx;
                            r_cmd.req <= r_req;
                            r_count   <= r_count + t_cnt'(1);
                        end
                    end else if (r_type && w_free_hit) begin
                        r_state   <= S_RESP;
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        r_cmd.op  <= CMD_FREE_MERGE;
                        r_cmd.idx <= r_idx;
                        r_cmd.merge_next <= (r_idx + t_cnt'(1) < r_count) && i_scan_next.free;
                        r_cmd.merge_prev <= (r_idx != '0) && i_scan_prev.free;
                        r_count <= r_count
                            - t_cnt'((r_idx + t_cnt'(1) < r_count) && i_scan_next.free)
                            - t_cnt'((r_idx != '0) && i_scan_prev.free);
                    end else begin
                        r_cmd.op <= CMD_HOLD;
                        r_idx    <= r_idx + t_cnt'(1);
                    end
                end
                S_RESP: begin
                    r_cmd.op <= CMD_HOLD;
                    if (i_rsp_ready) r_state <= S_IDLE;
                end
                default: begin
                    r_cmd.op <= CMD_HOLD;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== tb/sv/first_fit_allocator_top_tb.sv =====
// Self-checking testbench for the first-fit segment allocator top level.
`timescale 1ns / 100ps

module first_fit_allocator_top_tb;
    import ffa_pkg::*;

    localparam int ReqAlloc = 0;
    localparam int ReqFree  = 1;
    localparam int StallLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    logic        i_req_type = 1'b0;
    logic [16:0] i_req_size = '0;
    logic [15:0] i_free_offset = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_granted_offset;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;

    first_fit_allocator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the segment table.
    t_seg        seg_tab [MaxSegments];
    int          seg_cnt;
    logic [16:0] pool_bytes;

    typedef struct {
        t_status     st;
        logic [15:0] off;
    } t_grant;

    t_grant grant_q[$];
    logic [15:0] live_offs[$];
    int  error_cnt = 0;
    int  idle_cycles = 0;
    bit  hold_rsp = 0;
    bit  rsp_pattern_on = 1;

    // Clear the shadow table to one free segment of the current pool size.
    function automatic void table_reset();
        foreach (seg_tab[i]) seg_tab[i] = '0;
        seg_tab[0].start = '0;
        seg_tab[0].size  = pool_bytes;
        seg_tab[0].free  = 1'b1;
        seg_cnt = 1;
        live_offs.delete();
    endfunction

    function automatic void drop_seg(int idx);
        for (int j = idx; j < seg_cnt - 1; j++) seg_tab[j] = seg_tab[j+1];
        seg_cnt--;
        seg_tab[seg_cnt] = '0;
    endfunction

    // Predict the outcome of one request and update the shadow table.
    function automatic t_grant predict_grant(logic kind, logic [16:0] sz, logic [15:0] off);
        t_grant g;
        int i;
        g.st = ST_NOFIT;
        g.off = '0;
        if (kind == ReqAlloc) begin
            if (sz == 0) begin
                g.st = ST_BAD;
                return g;
            end
            for (i = 0; i < seg_cnt; i++) begin
                if (seg_tab[i].free && seg_tab[i].size >= sz) begin
                    if (seg_tab[i].size > sz) begin
                        if (seg_cnt >= MaxSegments) begin
                            g.st = ST_FULL;
                            return g;
                        end
                        for (int j = seg_cnt; j > i + 1; j--) seg_tab[j] = seg_tab[j-1];
                        seg_tab[i+1].start = seg_tab[i].start + sz[15:0];
                        seg_tab[i+1].size  = seg_tab[i].size - sz;
                        seg_tab[i+1].free  = 1'b1;
                        seg_cnt++;
                        seg_tab[i].size = sz;
                    end
                    seg_tab[i].free = 1'b0;
                    g.st = ST_OK;
                    g.off = seg_tab[i].start;
                    live_offs.push_back(g.off);
                    return g;
                end
            end
            return g;
        end
        for (i = 0; i < seg_cnt; i++)
            if (!seg_tab[i].free && seg_tab[i].start == off) break;
        if (i >= seg_cnt) begin
            g.st = ST_BAD;
            return g;
        end
        foreach (live_offs[k])
            if (live_offs[k] == off) begin
                live_offs.delete(k);
                break;
            end
        seg_tab[i].free = 1'b1;
        if (i + 1 < seg_cnt && seg_tab[i+1].free) begin
            seg_tab[i].size += seg_tab[i+1].size;
            drop_seg(i + 1);
        end
        if (i > 0 && seg_tab[i-1].free) begin
            seg_tab[i-1].size += seg_tab[i].size;
            drop_seg(i);
        end
        g.st = ST_OK;
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_cnt++;
    endtask

    // Send one request word and record its expected result.
    // The block is busy in the cycle after an accept, so dropping valid for that cycle costs nothing.
    task automatic send_req(logic kind, logic [16:0] sz, logic [15:0] off);
        i_req_valid   <= 1'b1;
        i_req_type    <= kind;
        i_req_size    <= sz;
        i_free_offset <= off;
        do @(posedge i_clk); while (!o_req_ready);
        grant_q.push_back(predict_grant(kind, sz, off));
        i_req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender with random bursts and gaps.
    task automatic send_paced(logic kind, logic [16:0] sz, logic [15:0] off);
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) @(posedge i_clk);
        send_req(kind, sz, off);
    endtask

    task automatic wait_drain();
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Write the pool size; the block must be idle.
    task automatic write_pool(logic [16:0] val);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_bytes = (val == 0) ? 17'd1 : (val > 17'd65536 ? 17'd65536 : val);
        table_reset();
    endtask

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected result", o_status, -1);
            end else begin
                t_grant g;
                g = grant_q.pop_front();
                if (o_status !== g.st) report_mismatch("status", o_status, g.st);
                if (o_granted_offset !== g.off)
                    report_mismatch("granted_offset", o_granted_offset, g.off);
            end
        end
    end

    // Receiver stall pattern, overridden by a long hold-off.
    always @(posedge i_clk) begin
        if (hold_rsp) i_rsp_ready <= 1'b0;
        else if (!rsp_pattern_on) i_rsp_ready <= 1'b1;
        else i_rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_edges();
        send_req(ReqAlloc, 17'd0, 16'd0);
        send_req(ReqAlloc, 17'd65536, 16'd0);
        send_req(ReqAlloc, 17'd1, 16'd0);
        send_req(ReqFree, 17'd0, 16'd0);
        send_req(ReqFree, 17'h1ffff, 16'hffff);
        send_req(ReqAlloc, 17'd65535, 16'd0);
        send_req(ReqAlloc, 17'd1, 16'd0);
        send_req(ReqAlloc, 17'd1, 16'd0);
        send_req(ReqFree, 17'd0, 16'd0);
        send_req(ReqFree, 17'd0, 16'hffff);
        send_req(ReqFree, 17'd0, 16'hffff);
        send_req(ReqAlloc, 17'd65536, 16'd0);
        send_req(ReqAlloc, 17'h1ffff, 16'd0);
    endtask

    // Fill the table so that a split finds it full.
    task automatic test_table_full();
        write_pool(17'd1000);
        for (int i = 0; i < MaxSegments + 1; i++) send_req(ReqAlloc, 17'd3, 16'h0);
        send_req(ReqAlloc, 17'd2000, 16'd0);
        send_req(ReqFree, 17'd0, 16'd3);
        send_req(ReqFree, 17'd0, 16'd9);
        send_req(ReqFree, 17'd0, 16'd6);
        send_req(ReqAlloc, 17'd9, 16'd0);
    endtask

    // Mostly well-formed alloc/free traffic with some noise.
    task automatic test_random(int n, logic [16:0] pool);
        logic [16:0] sz;
        logic [15:0] off;
        int pick;
        write_pool(pool);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                sz = ($urandom_range(0, 15) == 0) ? 17'($urandom)
                                                  : 17'($urandom_range(1, pool / 8 + 1));
                send_paced(ReqAlloc, sz, 16'($urandom));
            end else if (pick < 9 && live_offs.size() != 0) begin
                off = live_offs[$urandom_range(0, live_offs.size() - 1)];
                send_paced(ReqFree, 17'($urandom), off);
            end else begin
                send_paced(ReqFree, 17'($urandom), 16'($urandom));
            end
        end
    endtask

    // The receiver holds off while requests keep coming.
    task automatic test_backpressure();
        int hold_cnt;
        write_pool(17'd4096);
        hold_rsp = 1;
        fork
            begin
                for (hold_cnt = 0; hold_cnt < 400; hold_cnt++) @(posedge i_clk);
                hold_rsp = 0;
            end
            for (int i = 0; i < 20; i++) send_req(ReqAlloc, 17'($urandom_range(1, 64)), 16'd0);
        join
        wait_drain();
    endtask

    initial begin
        pool_bytes = 17'd65536;
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_table_full();
        write_pool(17'd0);
        send_req(ReqAlloc, 17'd1, 16'd0);
        send_req(ReqAlloc, 17'd1, 16'd0);
        send_req(ReqFree, 17'd0, 16'd0);
        write_pool(17'h1ffff);
        send_req(ReqAlloc, 17'd65536, 16'd0);
        test_backpressure();
        rsp_pattern_on = 0;
        test_random(150, 17'd65536);
        rsp_pattern_on = 1;
        test_random(350, 17'd256);
        test_random(350, 17'($urandom_range(1, 65536)));
        test_random(300, 17'd40);
        test_random(100, 17'd1);
        wait_drain();
        if (error_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/ffa_ctrl.sv
rtl/first_fit_allocator_top.sv
tb/sv/first_fit_allocator_top_tb.sv
